/* sv/feedback_echo_delay_macros.svh */
// Assertion macros shared by the checkers of the feedback echo delay.
`ifndef FEEDBACK_ECHO_DELAY_MACROS_SVH
`define FEEDBACK_ECHO_DELAY_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define FED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define FED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define FED_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/fed_pkg.sv */
// Shared types, constants and helpers of the feedback echo delay.
`timescale 1ns / 1ps
package fed_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int LEVEL_W   = 18;
    localparam int FRAC_W    = 17;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_LEVEL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_MOD_DEPTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_DRY        = 2'd3;

    localparam logic [FRAC_W-1:0]         FRAC_ONE  = 17'd65536;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 18'sd65536;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -18'sd65536;

    typedef struct packed {
        logic ld;
        logic fwd;
        logic mul1;
        logic mul2;
        logic mul3;
    } t_ctrl;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [17:0] x);
        logic signed [SAMPLE_W-1:0] y;
        if (x > 18'sd32767) begin
            y = 16'sh7fff;
        end else if (x < -18'sd32768) begin
            y = 16'sh8000;
        end else begin
            y = x[SAMPLE_W-1:0];
        end
        return y;
    endfunction

endpackage

/* sv/fed_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module fed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/fed_calc.sv */
// Arithmetic datapath: feedback amount, wet/dry mix and write-back value.
`timescale 1ns / 1ps
module fed_calc (
    input  logic                                  i_clk,
    input  fed_pkg::t_ctrl                        i_ctrl,
    input  logic signed [fed_pkg::LEVEL_W-1:0]    i_level,
    input  logic        [fed_pkg::FRAC_W-1:0]     i_depth,
    input  logic        [fed_pkg::FRAC_W-1:0]     i_wet_dry,
    input  logic signed [fed_pkg::SAMPLE_W-1:0]   i_dry,
    input  logic signed [fed_pkg::SAMPLE_W-1:0]   i_fb,
    input  logic signed [fed_pkg::SAMPLE_W-1:0]   i_mod,
    input  logic        [fed_pkg::SAMPLE_W-1:0]   i_rdata,
    output logic signed [fed_pkg::SAMPLE_W-1:0]   o_store,
    output logic signed [fed_pkg::SAMPLE_W-1:0]   o_mix,
    output logic signed [fed_pkg::SAMPLE_W-1:0]   o_wet
);
    import fed_pkg::*;

    logic signed [SAMPLE_W-1:0] r_dry;
    logic signed [SAMPLE_W-1:0] r_fb;
    logic signed [SAMPLE_W-1:0] r_mod;
    logic                       r_fwd;
    logic signed [SAMPLE_W-1:0] r_fwd_data;
    logic signed [35:0]         r_p1;
    logic signed [35:0]         r_p2;
    logic signed [51:0]         r_amt_raw;
    logic signed [33:0]         r_mix_sum;
    logic signed [SAMPLE_W-1:0] r_wet;
    logic signed [LEVEL_W-1:0]  r_amount;
    logic signed [SAMPLE_W-1:0] r_mix;
    logic signed [33:0]         r_fbprod;

    logic signed [SAMPLE_W-1:0] w_wet;
    logic signed [51:0]         w_p1_ext;
    logic signed [51:0]         w_amt_rnd;
    logic signed [33:0]         w_mix_rnd;
    logic signed [33:0]         w_fb_rnd;
    logic signed [17:0]         w_dry_ext;
    logic signed [17:0]         w_store_sum;
    logic signed [SAMPLE_W-1:0] w_store;

    // With a one-sample delay the read hits the entry written in the same cycle.
    assign w_wet       = r_fwd ? r_fwd_data : $signed(i_rdata);
    assign w_p1_ext    = r_p1;
    assign w_amt_rnd   = r_amt_raw + (52'sd1 <<< 30);
    assign w_mix_rnd   = r_mix_sum + 34'sd32768;
    assign w_fb_rnd    = r_fbprod + 34'sd32768;
    assign w_dry_ext   = r_dry;
    assign w_store_sum = w_dry_ext + $signed(w_fb_rnd[33:16]);
    assign w_store     = sat16(w_store_sum);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld) begin
            r_dry      <= i_dry;
            r_fb       <= i_fb;
            r_mod      <= i_mod;
            r_fwd      <= i_ctrl.fwd;
            r_fwd_data <= w_store;
            r_p1       <= i_level * $signed({1'b0, FRAC_ONE - i_depth});
            r_p2       <= i_level * $signed({1'b0, i_depth});
        end
        if (i_ctrl.mul1) begin
            r_wet     <= w_wet;
            r_amt_raw <= (w_p1_ext <<< 15) + r_p2 * r_mod;
            r_mix_sum <= r_dry * $signed({1'b0, FRAC_ONE - i_wet_dry})
                       + w_wet * $signed({1'b0, i_wet_dry});
        end
        if (i_ctrl.mul2) begin
            r_amount <= w_amt_rnd[48:31];
            r_mix    <= sat16($signed(w_mix_rnd[33:16]));
        end
        if (i_ctrl.mul3) begin
            r_fbprod <= r_fb * r_amount;
        end
    end

    assign o_store = w_store;
    assign o_mix   = r_mix;
    assign o_wet   = r_wet;

endmodule

/* sv/feedback_echo_delay.sv */
// Feedback echo delay: a circular delay memory with modulated feedback and a wet/dry mix.
// Each request carries a dry sample, a feedback sample and a modulation value and yields one
// result holding the mixed sample and the delayed (wet) sample. A request passes through the
// states MUL1, MUL2, MUL3 and WRITE from acceptance to result; a new request is taken in the
// cycle its predecessor writes back, so only one request is in work at a time, which follows
// from the chain of three registered multiply stages around the single delay memory. After
// reset the delay memory is cleared one entry per cycle, which keeps the input not ready until
// every entry is cleared; configuration writes are taken throughout. Writing the delay length
// restarts the position at length minus one, clamped to the memory, and keeps the memory contents.
`timescale 1ns / 1ps
module feedback_echo_delay #(
    parameter int MAX_DELAY = 32768
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fed_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fed_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // dry_sample [15:0], feedback_sample [31:16], feed_mod [47:32]
    input  logic [47:0]                     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // mix_out [15:0], wet_out [31:16]
    output logic [31:0]                     m_axis_tdata
);
    import fed_pkg::*;

    localparam int AW = $clog2(MAX_DELAY);
    localparam int CW = (LEN_W > AW + 1) ? LEN_W : AW + 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_DELAY);
    localparam logic [AW-1:0] RST_LEN_M1 =
        (MAX_DELAY < 32768) ? AW'(MAX_DELAY - 1) : AW'(32767);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DELAY - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL1  = 3'd1;
    localparam logic [2:0] S_MUL2  = 3'd2;
    localparam logic [2:0] S_MUL3  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    logic [2:0]                 r_state, n_state;
    logic                       r_clearing;
    logic [AW-1:0]              r_clr_addr;
    logic [AW-1:0]              r_pos, n_pos;
    logic [AW-1:0]              r_len_m1, n_len_m1;
    logic signed [LEVEL_W-1:0]  r_level;
    logic [FRAC_W-1:0]          r_depth;
    logic [FRAC_W-1:0]          r_wd;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_mix_out;
    logic [SAMPLE_W-1:0]        r_wet_out;

    logic                       w_accept;
    logic                       w_out_load;
    logic                       w_can_load;
    logic [AW-1:0]              w_pos_next;
    logic [AW-1:0]              w_rd_addr;
    logic [CW-1:0]              w_len_ext;
    logic [CW-1:0]              w_len_dec;
    logic signed [LEVEL_W-1:0]  w_lvl;
    logic [FRAC_W-1:0]          w_frac;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [SAMPLE_W-1:0]        w_wdata;
    logic [SAMPLE_W-1:0]        w_rdata;
    logic signed [SAMPLE_W-1:0] w_store;
    logic signed [SAMPLE_W-1:0] w_mix;
    logic signed [SAMPLE_W-1:0] w_wet;
    t_ctrl                      w_ctrl;

    assign w_can_load    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_clearing
                         && ((r_state == S_IDLE) || ((r_state == S_WRITE) && w_can_load));
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == S_WRITE) && w_can_load;
    assign w_pos_next    = (r_pos == '0) ? r_len_m1 : r_pos - 1'b1;
    assign w_rd_addr     = (r_state == S_WRITE) ? w_pos_next : r_pos;

    assign w_ctrl.ld   = w_accept;
    assign w_ctrl.fwd  = (r_state == S_WRITE) && (w_pos_next == r_pos);
    assign w_ctrl.mul1 = (r_state == S_MUL1);
    assign w_ctrl.mul2 = (r_state == S_MUL2);
    assign w_ctrl.mul3 = (r_state == S_MUL3);

    assign w_len_ext = CW'(i_cfg_data[LEN_W-1:0]);
    assign w_len_dec = w_len_ext - CW'(1);
    assign w_lvl     = $signed(i_cfg_data[LEVEL_W-1:0]);
    assign w_frac    = (i_cfg_data[FRAC_W-1:0] > FRAC_ONE) ? FRAC_ONE
                                                           : i_cfg_data[FRAC_W-1:0];

    always_comb begin
        if (w_len_ext == '0) begin
            n_len_m1 = '0;
        end else if (w_len_ext > MAX_C) begin
            n_len_m1 = LAST_ADDR;
        end else begin
            n_len_m1 = w_len_dec[AW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_WRITE;
            S_WRITE: begin
                if (w_out_load) begin
                    n_state = w_accept ? S_MUL1 : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_pos = r_pos;
        if (i_cfg_we && (i_cfg_index == CFG_DELAY_LENGTH)) begin
            n_pos = n_len_m1;
        end else if (w_out_load) begin
            n_pos = w_pos_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_pos       <= RST_LEN_M1;
            r_len_m1    <= RST_LEN_M1;
            r_level     <= '0;
            r_depth     <= '0;
            r_wd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            if (r_clearing) begin
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DELAY_LENGTH:   r_len_m1 <= n_len_m1;
                    CFG_FEED_LEVEL: begin
                        if (w_lvl > LEVEL_MAX) begin
                            r_level <= LEVEL_MAX;
                        end else if (w_lvl < LEVEL_MIN) begin
                            r_level <= LEVEL_MIN;
                        end else begin
                            r_level <= w_lvl;
                        end
                    end
                    CFG_FEED_MOD_DEPTH: r_depth <= w_frac;
                    CFG_WET_DRY:        r_wd    <= w_frac;
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_mix_out <= w_mix;
            r_wet_out <= w_wet;
        end
    end

    assign w_we    = r_clearing || w_out_load;
    assign w_waddr = r_clearing ? r_clr_addr : r_pos;
    assign w_wdata = r_clearing ? '0 : w_store;

    fed_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    fed_calc u_calc (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_level   (r_level),
        .i_depth   (r_depth),
        .i_wet_dry (r_wd),
        .i_dry     ($signed(s_axis_tdata[15:0])),
        .i_fb      ($signed(s_axis_tdata[31:16])),
        .i_mod     ($signed(s_axis_tdata[47:32])),
        .i_rdata   (w_rdata),
        .o_store   (w_store),
        .o_mix     (w_mix),
        .o_wet     (w_wet)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_wet_out, r_mix_out};

endmodule

/* sv/fed_checker.sv */
// Port-level checker of the feedback echo delay and its bind to the top level.
`timescale 1ns / 1ps
`include "feedback_echo_delay_macros.svh"
module fed_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    `FED_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
    `FED_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
    `FED_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while one is in work")
    `FED_ASSERT_RESET(a_reset_quiet, !i_rst_n, !m_axis_tvalid && !s_axis_tready, "activity right after reset")

endmodule

bind feedback_echo_delay fed_checker u_fed_checker (.*);
